// ----- src/sialu_pkg.sv -----
`timescale 1ns / 1ps

package sialu_pkg;

	// Operand and result width.
	localparam int unsigned DW = 64;
	// One quotient bit is resolved in each divider stage.
	localparam int unsigned DIV_STAGES = DW;
	// Half width used to split the multiply into partial products.
	localparam int unsigned HW = DW / 2;

	// Command codes; the remaining codes give a zero result.
	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3
	} cmd_t;

	// Information that rides along with every request through the divider.
	typedef struct packed {
		cmd_t            cmd;
		logic            neg;
		logic            dz;
		logic [DW-1:0]   res;
	} side_t;

endpackage

// ----- src/sialu_front.sv -----
`timescale 1ns / 1ps

module sialu_front import sialu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  cmd_t          cmd_in,
	input  logic [DW-1:0] a_in,
	input  logic [DW-1:0] b_in,
	output logic          v_out,
	output side_t         side_out,
	output logic [DW-1:0] rem_out,
	output logic [DW-1:0] quo_out,
	output logic [DW-1:0] den_out
);

	logic          v_s2;
	cmd_t          cmd_s2;
	logic [DW-1:0] res_s2;
	logic [DW-1:0] p0_s2;
	logic [HW-1:0] p1_s2;
	logic [HW-1:0] p2_s2;
	logic [DW-1:0] ma_s2;
	logic [DW-1:0] mb_s2;
	logic          neg_s2;
	logic          dz_s2;

	logic          v_s3;
	side_t         side_s3;
	logic [DW-1:0] quo_s3;
	logic [DW-1:0] den_s3;

	logic [DW-1:0] res_c;
	logic [HW-1:0] cross_c;
	logic [DW-1:0] mul_c;

	// Add and subtract results; unknown commands collapse to zero here.
	always_comb begin
		case (cmd_in)
			CMD_ADD: res_c = a_in + b_in;
			CMD_SUB: res_c = a_in - b_in;
			default: res_c = '0;
		endcase
	end

	// Valid bits for the two front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_in;
			v_s3 <= v_s2;
		end
	end

	// Stage 2: partial products, magnitudes and divide flags.
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_in;
			res_s2 <= res_c;
			p0_s2  <= a_in[HW-1:0] * b_in[HW-1:0];
			p1_s2  <= HW'(a_in[HW-1:0] * b_in[DW-1:HW]);
			p2_s2  <= HW'(a_in[DW-1:HW] * b_in[HW-1:0]);
			ma_s2  <= a_in[DW-1] ? (~a_in + 1'b1) : a_in;
			mb_s2  <= b_in[DW-1] ? (~b_in + 1'b1) : b_in;
			neg_s2 <= a_in[DW-1] ^ b_in[DW-1];
			dz_s2  <= (b_in == '0);
		end
	end

	// Combine the partial products into the low half of the product.
	assign cross_c = p1_s2 + p2_s2;
	assign mul_c   = p0_s2 + {cross_c, {HW{1'b0}}};

	// Stage 3: final product selection and divider seed.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.cmd <= cmd_s2;
			side_s3.neg <= neg_s2;
			side_s3.dz  <= dz_s2;
			side_s3.res <= (cmd_s2 == CMD_MUL) ? mul_c : res_s2;
			quo_s3      <= ma_s2;
			den_s3      <= mb_s2;
		end
	end

	assign v_out    = v_s3;
	assign side_out = side_s3;
	assign rem_out  = '0;
	assign quo_out  = quo_s3;
	assign den_out  = den_s3;

endmodule

// ----- src/sialu_div_stage.sv -----
`timescale 1ns / 1ps

module sialu_div_stage import sialu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  side_t         side_in,
	input  logic [DW-1:0] rem_in,
	input  logic [DW-1:0] quo_in,
	input  logic [DW-1:0] den_in,
	output logic          v_out,
	output side_t         side_out,
	output logic [DW-1:0] rem_out,
	output logic [DW-1:0] quo_out,
	output logic [DW-1:0] den_out
);

	logic          v_s1;
	side_t         side_s1;
	logic [DW-1:0] rem_s1;
	logic [DW-1:0] quo_s1;
	logic [DW-1:0] den_s1;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign trial = {rem_in, quo_in[DW-1]};
	assign diff  = trial - {1'b0, den_in};
	assign ge    = !diff[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			rem_s1  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_s1  <= {quo_in[DW-2:0], ge};
			den_s1  <= den_in;
		end
	end

	assign v_out    = v_s1;
	assign side_out = side_s1;
	assign rem_out  = rem_s1;
	assign quo_out  = quo_s1;
	assign den_out  = den_s1;

endmodule

// ----- src/signed_integer_alu_with_divide.sv -----
`timescale 1ns / 1ps

// Signed 64-bit integer ALU: add, subtract, multiply (low 64 bits) and
// divide truncated toward zero, all with two's-complement wrap.
// The request channel (in_valid, in_ready) carries command, operand_a and
// operand_b; the result channel (out_valid, out_ready) carries result.
// Divide by zero and the unused command codes give zero; the most negative
// value divided by minus one wraps to the most negative value.
// Every request passes from acceptance to a valid result through one
// input register, two front stages for the split multiply and operand
// magnitudes, 64 divider stages that each resolve one quotient bit, and the
// output register. All commands flow through the same pipeline, so results
// leave in request order.
// Throughput is one request per cycle while the receiver takes results.
// When the receiver stalls, the whole pipeline holds and in_ready drops in
// the same cycle; nothing is lost or repeated.
// Reset clears every valid bit, so the pipeline comes up empty.
module signed_integer_alu_with_divide import sialu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    command,
	input  logic [DW-1:0] operand_a,
	input  logic [DW-1:0] operand_b,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] result
);

	logic          adv;
	logic          v_s1;
	cmd_t          cmd_s1;
	logic [DW-1:0] a_s1;
	logic [DW-1:0] b_s1;
	logic          out_v_q;
	logic [DW-1:0] result_q;

	logic          v_w    [DIV_STAGES+1];
	side_t         side_w [DIV_STAGES+1];
	logic [DW-1:0] rem_w  [DIV_STAGES+1];
	logic [DW-1:0] quo_w  [DIV_STAGES+1];
	logic [DW-1:0] den_w  [DIV_STAGES+1];

	side_t         side_l;
	logic [DW-1:0] quo_l;
	logic [DW-1:0] q_signed;

	// The pipeline moves whenever the output register is free or drained.
	assign adv      = !out_v_q || out_ready;
	assign in_ready = adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_t'(command);
			a_s1   <= operand_a;
			b_s1   <= operand_b;
		end
	end

	// Partial products, magnitudes and divider seed.
	sialu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.v_in     (v_s1),
		.cmd_in   (cmd_s1),
		.a_in     (a_s1),
		.b_in     (b_s1),
		.v_out    (v_w[0]),
		.side_out (side_w[0]),
		.rem_out  (rem_w[0]),
		.quo_out  (quo_w[0]),
		.den_out  (den_w[0])
	);

	// Divider chain, one quotient bit per stage.
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		sialu_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.v_in     (v_w[i]),
			.side_in  (side_w[i]),
			.rem_in   (rem_w[i]),
			.quo_in   (quo_w[i]),
			.den_in   (den_w[i]),
			.v_out    (v_w[i+1]),
			.side_out (side_w[i+1]),
			.rem_out  (rem_w[i+1]),
			.quo_out  (quo_w[i+1]),
			.den_out  (den_w[i+1])
		);
	end

	// Apply the quotient sign and pick the final result.
	assign side_l   = side_w[DIV_STAGES];
	assign quo_l    = quo_w[DIV_STAGES];
	assign q_signed = side_l.neg ? (~quo_l + 1'b1) : quo_l;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_w[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_l.cmd == CMD_DIV) begin
				result_q <= side_l.dz ? '0 : q_signed;
			end else begin
				result_q <= side_l.res;
			end
		end
	end

	assign out_valid = out_v_q;
	assign result    = result_q;

endmodule

// ----- src/sialu_checker.sv -----
`timescale 1ns / 1ps

module sialu_checker import sialu_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic [DW-1:0] result
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("result changed while stalled");

	// The pipeline takes requests exactly when the output side can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output side");

	// No request is taken in a cycle where the result is stalled.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !(in_valid && in_ready))
		else $error("request accepted while the output was stalled");

	// A valid result never carries unknown bits.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(result))
		else $error("unknown bits on a valid result");

endmodule

bind signed_integer_alu_with_divide sialu_checker u_sialu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.result    (result)
);
